### design/spa_pkg.sv
package spa_pkg;

    localparam int STRIPS_PER_EVENT = 36;

    localparam int STRIP_W     = 8;
    localparam int EN_IN_W     = 13;
    localparam int ENERGY_W    = 16;
    localparam int COUNT_W     = 8;
    localparam int WSUM_W      = 24;
    localparam int PROD_W      = COUNT_W + EN_IN_W;

    localparam logic [STRIP_W-1:0] LAST_STRIP = STRIP_W'(STRIPS_PER_EVENT - 1);

    // Output queue: up to two results per strip, one leaves per cycle while the consumer is ready.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [EN_IN_W-1:0] strip_energy;
        logic               open_mark;
        logic               fill_mark;
        logic               close_mark;
        logic               event_end;
    } strip_item_t;

    typedef struct packed {
        logic [WSUM_W-1:0]   weighted;
        logic [COUNT_W-1:0]  count;
        logic [STRIP_W-1:0]  first;
        logic [ENERGY_W-1:0] energy;
    } slot_rec_t;

    // Packed so that slot_index sits in the lowest bits.
    typedef struct packed {
        logic                final_slot;
        logic [WSUM_W-1:0]   weighted_sum;
        logic [COUNT_W-1:0]  strip_count;
        logic [STRIP_W-1:0]  first_strip;
        logic [ENERGY_W-1:0] peak_energy_out;
        logic [STRIP_W-1:0]  slot_index;
    } result_t;

    typedef struct packed {
        logic    a_valid;
        result_t a;
        logic    b_valid;
        result_t b;
    } result_pair_t;

    function automatic result_t make_result(slot_rec_t rec, logic [STRIP_W-1:0] slot,
                                            logic fin, logic [ENERGY_W-1:0] thr);
        result_t r;
        r.final_slot      = fin;
        r.weighted_sum    = rec.weighted;
        r.strip_count     = rec.count;
        r.first_strip     = rec.first;
        r.peak_energy_out = (rec.energy < thr) ? '0 : rec.energy;
        r.slot_index      = slot;
        return r;
    endfunction

endpackage

### design/spa_strip_proc.sv
module spa_strip_proc
    import spa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  strip_item_t         in_item,
    input  logic [ENERGY_W-1:0] threshold,
    input  logic                room,
    output result_pair_t        results
);

    strip_item_t          item_reg;
    logic                 item_valid_reg, item_valid_next;
    logic [STRIP_W-1:0]   strip_reg, strip_next;
    logic [STRIP_W-1:0]   start_reg, start_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [ENERGY_W-1:0]  energy_reg, energy_next;
    logic [WSUM_W-1:0]    wsum_reg, wsum_next;
    slot_rec_t            prev_slot_reg, prev_slot_next;
    slot_rec_t            cur_slot_reg, cur_slot_next;

    logic                 fire;
    logic                 last;
    logic [STRIP_W-1:0]   start_upd;
    logic [COUNT_W-1:0]   count_upd;
    logic [ENERGY_W-1:0]  energy_upd;
    logic [WSUM_W-1:0]    wsum_upd;
    logic [PROD_W-1:0]    prod;
    slot_rec_t            rec;
    slot_rec_t            prev_slot_upd, cur_slot_upd;

    assign fire     = item_valid_reg && room;
    assign in_ready = !item_valid_reg || fire;

    always_comb begin
        last      = item_reg.event_end || (strip_reg >= LAST_STRIP);
        start_upd = item_reg.open_mark ? strip_reg : start_reg;

        count_upd  = item_reg.fill_mark ? count_reg + 1'b1 : count_reg;
        prod       = {{EN_IN_W{1'b0}}, count_upd} * {{COUNT_W{1'b0}}, item_reg.strip_energy};
        energy_upd = energy_reg;
        wsum_upd   = wsum_reg;
        if (item_reg.fill_mark) begin
            energy_upd = energy_reg + ENERGY_W'(item_reg.strip_energy);
            wsum_upd   = wsum_reg + WSUM_W'(prod);
        end

        rec.energy   = energy_upd;
        rec.first    = start_upd;
        rec.count    = count_upd;
        rec.weighted = wsum_upd;

        // A one-strip peak belongs to this strip, any other to the strip before (none at strip zero).
        prev_slot_upd = prev_slot_reg;
        cur_slot_upd  = cur_slot_reg;
        if (item_reg.close_mark) begin
            if (count_upd == COUNT_W'(1)) begin
                cur_slot_upd = rec;
            end else if (strip_reg != '0) begin
                prev_slot_upd = rec;
            end
        end

        results.a_valid = fire && (strip_reg != '0);
        results.a       = make_result(prev_slot_upd, strip_reg - 1'b1, 1'b0, threshold);
        results.b_valid = fire && last;
        results.b       = make_result(cur_slot_upd, strip_reg, 1'b1, threshold);

        item_valid_next = item_valid_reg;
        if (in_valid && in_ready) begin
            item_valid_next = 1'b1;
        end else if (fire) begin
            item_valid_next = 1'b0;
        end

        strip_next     = strip_reg;
        start_next     = start_reg;
        count_next     = count_reg;
        energy_next    = energy_reg;
        wsum_next      = wsum_reg;
        prev_slot_next = prev_slot_reg;
        cur_slot_next  = cur_slot_reg;
        if (fire) begin
            if (last || item_reg.close_mark) begin
                start_next  = '0;
                count_next  = '0;
                energy_next = '0;
                wsum_next   = '0;
            end else begin
                start_next  = start_upd;
                count_next  = count_upd;
                energy_next = energy_upd;
                wsum_next   = wsum_upd;
            end
            if (last) begin
                strip_next     = '0;
                prev_slot_next = '0;
                cur_slot_next  = '0;
            end else begin
                strip_next     = strip_reg + 1'b1;
                prev_slot_next = cur_slot_upd;
                cur_slot_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            strip_reg      <= '0;
            start_reg      <= '0;
            count_reg      <= '0;
            energy_reg     <= '0;
            wsum_reg       <= '0;
            prev_slot_reg  <= '0;
            cur_slot_reg   <= '0;
        end else begin
            item_valid_reg <= item_valid_next;
            strip_reg      <= strip_next;
            start_reg      <= start_next;
            count_reg      <= count_next;
            energy_reg     <= energy_next;
            wsum_reg       <= wsum_next;
            prev_slot_reg  <= prev_slot_next;
            cur_slot_reg   <= cur_slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

### design/spa_out_fifo.sv
module spa_out_fifo
    import spa_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  result_pair_t push,
    output logic         room,
    output logic         out_valid,
    input  logic         out_ready,
    output result_t      out_data
);

    result_t                entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;

    logic                   pop;
    logic                   we0, we1;
    result_t                wd0, wd1;
    logic [FIFO_PTR_W-1:0]  wr_ptr_p1;
    logic [FIFO_CNT_W-1:0]  n_push;

    assign room      = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    // The two results of one strip are packed into consecutive entries.
    always_comb begin
        if (push.a_valid) begin
            we0 = 1'b1;
            wd0 = push.a;
            we1 = push.b_valid;
        end else begin
            we0 = push.b_valid;
            wd0 = push.b;
            we1 = 1'b0;
        end
        wd1    = push.b;
        n_push = FIFO_CNT_W'(we0) + FIFO_CNT_W'(we1);

        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + n_push - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (we0) begin
            entry_reg[wr_ptr_reg] <= wd0;
        end
        if (we1) begin
            entry_reg[wr_ptr_p1] <= wd1;
        end
    end

endmodule

### design/strip_peak_accumulator_core.sv
// A strip transaction is registered in the update stage, and its slot records are written to
// the four-entry output queue once it has room; m_tvalid rises when the first record is queued
// and the final slot of an event follows the record of the strip before it.
// Throughput: one strip per cycle while the queue has room, set by the single update stage
// (register to register); the output drains one record per cycle while m_tready is high.
// Reset: synchronous, active low; clears strip counter, accumulators, slots and threshold.
module strip_peak_accumulator_core
    import spa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [ENERGY_W-1:0] cfg_wr_data,   // energy_threshold
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,       // [12:0] strip_energy, rest zero
    input  logic [2:0]          s_tuser,       // [0] open_mark, [1] fill_mark, [2] close_mark
    input  logic                s_tlast,       // event_end
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [63:0]         m_tdata,       // slot_index, peak_energy_out, first_strip,
                                               // strip_count, weighted_sum (low to high)
    output logic                m_tlast        // final_slot
);

    logic [ENERGY_W-1:0] threshold_reg;
    strip_item_t         item;
    result_pair_t        pair;
    result_t             head;
    logic                room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= '0;
        end else if (cfg_wr_en) begin
            threshold_reg <= cfg_wr_data;
        end
    end

    assign item.strip_energy = s_tdata[EN_IN_W-1:0];
    assign item.open_mark    = s_tuser[0];
    assign item.fill_mark    = s_tuser[1];
    assign item.close_mark   = s_tuser[2];
    assign item.event_end    = s_tlast;

    spa_strip_proc u_proc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .threshold (threshold_reg),
        .room      (room),
        .results   (pair)
    );

    spa_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (pair),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tdata = head[63:0];
    assign m_tlast = head.final_slot;

`ifndef ASSERT_OFF
    // The update stage may only produce results when the queue can take both.
    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (pair.a_valid || pair.b_valid) |-> room)
        else $error("results produced without queue room");

    // A produced result must be visible on the master side in the next cycle.
    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (pair.a_valid || pair.b_valid) |=> m_tvalid)
        else $error("produced result not presented");

    // The final slot of an event is the second result only when both are present.
    a_final_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pair.a_valid |-> !pair.a.final_slot)
        else $error("final slot marked on the previous-strip record");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import spa_pkg::*;

    logic                aclk;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [ENERGY_W-1:0] cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata     = '0;   // [12:0] strip_energy, rest zero
    logic [2:0]          s_tuser     = '0;   // [0] open_mark, [1] fill_mark, [2] close_mark
    logic                s_tlast     = 1'b0; // event_end
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [63:0]         m_tdata;            // slot_index, peak_energy_out, first_strip,
                                             // strip_count, weighted_sum (low to high)
    logic                m_tlast;            // final_slot

    strip_peak_accumulator_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // Shadow copy of the block's strip and peak state.
    logic [ENERGY_W-1:0] energy_threshold = '0;
    logic [STRIP_W-1:0]  strip_idx        = '0;
    logic [STRIP_W-1:0]  pk_first         = '0;
    logic [COUNT_W-1:0]  pk_count         = '0;
    logic [ENERGY_W-1:0] pk_energy        = '0;
    logic [WSUM_W-1:0]   pk_wsum          = '0;
    slot_rec_t           slot_prev        = '0;
    slot_rec_t           slot_now         = '0;

    result_t slot_records_due[$];

    int src_idle_pct    = 0;
    int sink_stall_pct  = 0;
    int mismatch_count  = 0;
    int records_seen    = 0;
    int strips_sent     = 0;
    int events_done     = 0;
    int threshold_count = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("strip_peak_accumulator_core verification failed");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic strip_item_t mk(input logic [EN_IN_W-1:0] en, input logic op,
                                       input logic fl, input logic cl, input logic ev);
        strip_item_t it;
        it.strip_energy = en;
        it.open_mark    = op;
        it.fill_mark    = fl;
        it.close_mark   = cl;
        it.event_end    = ev;
        return it;
    endfunction

    function automatic logic [EN_IN_W-1:0] rand_energy();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return EN_IN_W'($urandom_range(0, 8191));
        endcase
    endfunction

    task automatic queue_record(input slot_rec_t rec, input logic [STRIP_W-1:0] slot,
                                input logic fin);
        result_t r;
        r.slot_index      = slot;
        r.peak_energy_out = (rec.energy < energy_threshold) ? '0 : rec.energy;
        r.first_strip     = rec.first;
        r.strip_count     = rec.count;
        r.weighted_sum    = rec.weighted;
        r.final_slot      = fin;
        slot_records_due.push_back(r);
    endtask

    task automatic clear_peak();
        pk_first  = '0;
        pk_count  = '0;
        pk_energy = '0;
        pk_wsum   = '0;
    endtask

    // Marks on one strip take effect in the order open, fill, close.
    task automatic predict_slot_records(input strip_item_t it);
        logic      at_end;
        slot_rec_t rec;
        at_end = it.event_end || (strip_idx >= LAST_STRIP);
        if (it.open_mark) pk_first = strip_idx;
        if (it.fill_mark) begin
            pk_energy = pk_energy + ENERGY_W'(it.strip_energy);
            pk_count  = pk_count + 1'b1;
            pk_wsum   = pk_wsum + WSUM_W'(pk_count) * WSUM_W'(it.strip_energy);
        end
        if (it.close_mark) begin
            rec.energy   = pk_energy;
            rec.first    = pk_first;
            rec.count    = pk_count;
            rec.weighted = pk_wsum;
            // A one-strip peak belongs to this strip, anything else to the one before;
            // at strip zero there is no strip before, so the peak is lost.
            if (pk_count == 1) slot_now = rec;
            else if (strip_idx != 0) slot_prev = rec;
            clear_peak();
        end
        if (strip_idx != 0) queue_record(slot_prev, strip_idx - 1'b1, 1'b0);
        if (at_end) begin
            queue_record(slot_now, strip_idx, 1'b1);
            strip_idx = '0;
            clear_peak();
            slot_prev = '0;
            slot_now  = '0;
            events_done++;
        end else begin
            slot_prev = slot_now;
            slot_now  = '0;
            strip_idx = strip_idx + 1'b1;
        end
    endtask

    task automatic send_strip(input strip_item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, it.strip_energy};
        s_tuser  <= {it.close_mark, it.fill_mark, it.open_mark};
        s_tlast  <= it.event_end;
        do @(posedge aclk); while (!s_tready);
        predict_slot_records(it);
        strips_sent++;
    endtask

    task automatic wait_records_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (slot_records_due.size() != 0) @(posedge aclk);
        // A strip that emits nothing may still be in flight.
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [ENERGY_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        energy_threshold = value;
        threshold_count++;
    endtask

    task automatic test_single_strip_events();
        write_threshold('0);
        send_strip(mk('1, 1'b1, 1'b1, 1'b1, 1'b1));
        send_strip(mk('0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_strip(mk('1, 1'b0, 1'b0, 1'b0, 1'b1));
        send_strip(mk(13'h1234, 1'b1, 1'b0, 1'b0, 1'b1));
        wait_records_drained();
    endtask

    task automatic test_peak_corner_cases();
        send_strip(mk(13'd100, 1'b1, 1'b0, 1'b1, 1'b0)); // empty peak closed at strip zero
        send_strip(mk('1, 1'b0, 1'b1, 1'b0, 1'b0));       // fill without an open
        send_strip(mk(13'h1555, 1'b0, 1'b1, 1'b1, 1'b0));
        send_strip(mk(13'h0AAA, 1'b1, 1'b1, 1'b1, 1'b0));
        send_strip(mk('0, 1'b0, 1'b0, 1'b1, 1'b0));       // overwrites the slot just filled
        send_strip(mk(13'd1, 1'b1, 1'b1, 1'b0, 1'b0));
        send_strip(mk('1, 1'b0, 1'b1, 1'b0, 1'b0));
        send_strip(mk(13'd2, 1'b0, 1'b1, 1'b1, 1'b1));
        wait_records_drained();
    endtask

    task automatic test_threshold_edges();
        write_threshold(16'd8191);
        send_strip(mk('1, 1'b1, 1'b1, 1'b1, 1'b1));
        send_strip(mk(13'd8190, 1'b1, 1'b1, 1'b1, 1'b1));
        wait_records_drained();
        write_threshold('1);
        send_strip(mk('1, 1'b1, 1'b1, 1'b1, 1'b1));
        send_strip(mk('0, 1'b0, 1'b0, 1'b0, 1'b1));
        wait_records_drained();
        write_threshold(16'd1);
    endtask

    // A full-length event with no end mark; the energy sum wraps past 16 bits.
    task automatic test_long_event();
        for (int k = 0; k < STRIPS_PER_EVENT; k++) begin
            send_strip(mk('1, k == 0, 1'b1, k == STRIPS_PER_EVENT - 1, 1'b0));
        end
        send_strip(mk(13'd7, 1'b1, 1'b1, 1'b1, 1'b1));
        wait_records_drained();
    endtask

    task automatic run_random_events(input int n_items, input int src_pct, input int sink_pct,
                                     input bit pause_midway);
        int          sent;
        int          len;
        int          left;
        bit          in_peak;
        bit          paused;
        bit          long_evt;
        strip_item_t it;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        sent   = 0;
        paused = 0;
        left   = 0;
        while (sent < n_items) begin
            long_evt = ($urandom_range(99) < 8);
            if (long_evt) len = STRIPS_PER_EVENT;
            else if ($urandom_range(9) < 7) len = $urandom_range(1, 12);
            else len = $urandom_range(13, STRIPS_PER_EVENT);
            in_peak = 0;
            for (int k = 0; k < len; k++) begin
                it.strip_energy = rand_energy();
                if ($urandom_range(99) < 15) begin
                    {it.open_mark, it.fill_mark, it.close_mark} = 3'($urandom);
                end else if (!in_peak) begin
                    it.open_mark  = ($urandom_range(99) < 55);
                    it.fill_mark  = it.open_mark;
                    left          = $urandom_range(0, 5);
                    it.close_mark = it.open_mark && (left == 0);
                    in_peak       = it.open_mark && (left != 0);
                end else begin
                    it.open_mark  = 1'b0;
                    it.fill_mark  = ($urandom_range(9) != 0);
                    left--;
                    it.close_mark = (left <= 0);
                    in_peak       = (left > 0);
                end
                it.event_end = (k == len - 1) && !long_evt;
                send_strip(it);
                sent++;
                if (pause_midway && !paused && sent >= n_items / 2) begin
                    wait_records_drained();
                    paused = 1;
                end
            end
        end
        wait_records_drained();
    endtask

    task automatic test_random_traffic();
        write_threshold('0);
        run_random_events(375, 0, 0, 1'b0);
        write_threshold(ENERGY_W'($urandom_range(1, 30000)));
        run_random_events(375, 70, 0, 1'b1);
        write_threshold(ENERGY_W'($urandom_range(0, 65535)));
        run_random_events(375, 0, 70, 1'b0);
        write_threshold(ENERGY_W'($urandom_range(1, 20000)));
        run_random_events(375, 20, 20, 1'b0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : record_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'({m_tlast, m_tdata});
            if (slot_records_due.size() == 0) begin
                $error("slot record for slot %0d arrived with none outstanding",
                       got.slot_index);
                mismatch_count++;
            end else begin
                want = slot_records_due.pop_front();
                check_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
                check_field("peak_energy_out", 32'(want.peak_energy_out),
                            32'(got.peak_energy_out));
                check_field("first_strip", 32'(want.first_strip), 32'(got.first_strip));
                check_field("strip_count", 32'(want.strip_count), 32'(got.strip_count));
                check_field("weighted_sum", 32'(want.weighted_sum), 32'(got.weighted_sum));
                check_field("final_slot", 32'(want.final_slot), 32'(got.final_slot));
                records_seen++;
            end
        end
    end

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        test_single_strip_events();
        test_peak_corner_cases();
        test_threshold_edges();
        test_long_event();
        test_random_traffic();

        $display("Ran %0d strips in %0d events under %0d threshold settings and four",
                 strips_sent, events_done, threshold_count);
        $display("handshake pressure mixes; %0d slot records compared.", records_seen);
        if (mismatch_count == 0 && slot_records_due.size() == 0) begin
            $display("strip_peak_accumulator_core verification clean");
        end else begin
            $display("strip_peak_accumulator_core verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
design/spa_pkg.sv
design/spa_strip_proc.sv
design/spa_out_fifo.sv
design/strip_peak_accumulator_core.sv
dv/tb_top.sv
